// ----- rtl/bclr_pkg.sv -----
`timescale 1ns / 1ps
package bclr_pkg;

   // request actions
   typedef enum logic [1:0] {
      ACT_USE  = 2'd0,
      ACT_WORD = 2'd1,
      ACT_FAIL = 2'd2,
      ACT_SAFE = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_BUSY      = 2'd3
   } status_type;

   // control register indexes
   typedef enum logic [1:0] {
      CSR_WATERMARK = 2'd0,
      CSR_DMA_LIMIT = 2'd1,
      CSR_RING_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_POP  = 2'd1,
      FSM_SAFE = 2'd2,
      FSM_HOLD = 2'd3
   } fsm_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int WM_W       = 9;
   localparam int LIMIT_W    = 16;
   localparam int SEQ_W      = 32;

   localparam logic [1:0] HALVES_ALL = 2'b11;
   localparam logic [1:0] HALF_LO    = 2'b01;
   localparam logic [1:0] HALF_HI    = 2'b10;

   localparam logic [WM_W-1:0]    WM_RESET   = 9'd32;
   localparam logic [LIMIT_W-1:0] DMA_RESET  = 16'd16;
   localparam logic [LIMIT_W-1:0] RING_RESET = 16'd8;

   typedef struct packed {
      logic [1:0]       action;
      logic             half;
      logic [4:0]       word_index;
      logic [31:0]      buffer_word;
      logic             last_word;
      logic [SEQ_W-1:0] issued_seq;
      logic [SEQ_W-1:0] completed_seq;
      logic [SEQ_W-1:0] served_seq;
   } req_type;

   typedef struct packed {
      logic [31:0]      buffer_handle;
      logic             buffer_valid;
      logic [1:0]       status;
      logic             refill_request;
      logic [8:0]       available;
      logic [SEQ_W-1:0] safe_seq;
   } rsp_type;

   // operands for the safe sequence unit
   typedef struct packed {
      logic [SEQ_W-1:0]   issued_seq;
      logic [SEQ_W-1:0]   completed_seq;
      logic [SEQ_W-1:0]   served_seq;
      logic [LIMIT_W-1:0] dma_limit;
      logic [LIMIT_W-1:0] ring_limit;
   } safe_args_type;

endpackage

// ----- rtl/buffer_cache_lifo_refill.sv -----
`timescale 1ns / 1ps
// Buffer handle cache with a two-half refill engine.
// Requests arrive on req_valid / req_data and are taken when req_stall is low;
// results leave on rsp_valid / rsp_data, held while rsp_stall is high.
// Every request yields exactly one result, in order.
// One request is in flight at a time. A result passes the result register and
// the HOLD state on its way to the output register; a use first spends the POP
// state on the synchronous store read, and a safe sequence request waits in the
// SAFE state for the three-stage divide and min unit. req_stall stays high all
// that time, so no new request is taken before the result has left HOLD.
// A new request is accepted once the previous one has moved to the output
// register, even while that result still waits on rsp_stall.
// csr_write_en writes the watermark, DMA limit or ring limit register by
// csr_index; writes are meant only while no request is in flight.
// Synchronous reset empties the cache, marks both halves done, clears the safe
// sequence and loads the default register values; the handle store is not
// cleared, so a slot never written reads back undefined.
module buffer_cache_lifo_refill #(
   parameter int STORE_DEPTH = 256,
   parameter int POP_SIZE    = 16,
   parameter int BATCH_SIZE  = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bclr_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bclr_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_en,
   input  logic [bclr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bclr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bclr_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int SLOT_W = CNT_W + 1;
   localparam int CMP_W  = CNT_W + WM_W;
   localparam logic [SLOT_W-1:0] DEPTH_S = SLOT_W'(STORE_DEPTH);
   localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(STORE_DEPTH);
   localparam logic [SLOT_W-1:0] POP_S   = SLOT_W'(POP_SIZE);
   localparam logic [4:0]        POP_W   = 5'(POP_SIZE);

   fsm_type            state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [1:0]         halves_ff, halves_in;
   logic               hip_ff, hip_in;
   logic [SEQ_W-1:0]   safe_seq_ff, safe_seq_in;
   logic [WM_W-1:0]    wm_ff;
   logic [LIMIT_W-1:0] dma_limit_ff, ring_limit_ff;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [31:0]       mem_rdata;
   logic              safe_start, safe_done;
   logic [31:0]       safe_result;
   safe_args_type     safe_args;

   logic [1:0]        hbit;
   logic [SLOT_W-1:0] slot, commit;
   logic [CNT_W-1:0]  free_slots;

   bclr_store #(
      .DEPTH (STORE_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(req_data.buffer_word),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign safe_args.issued_seq    = req_data.issued_seq;
   assign safe_args.completed_seq = req_data.completed_seq;
   assign safe_args.served_seq    = req_data.served_seq;
   assign safe_args.dma_limit     = dma_limit_ff;
   assign safe_args.ring_limit    = ring_limit_ff;

   bclr_safe #(
      .CNT_W     (CNT_W),
      .BATCH_SIZE(BATCH_SIZE)
   ) u_safe (
      .clock (clock),
      .reset (reset),
      .start (safe_start),
      .args  (safe_args),
      .fill  (fill_ff),
      .done  (safe_done),
      .result(safe_result)
   );

   assign req_stall = (state_ff != FSM_IDLE);
   assign accept    = req_valid && (state_ff == FSM_IDLE);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      halves_in    = halves_ff;
      hip_in       = hip_ff;
      safe_seq_in  = safe_seq_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = ADDR_W'(fill_ff - CNT_W'(1));
      safe_start   = 1'b0;
      hbit         = req_data.half ? HALF_HI : HALF_LO;
      slot         = SLOT_W'(fill_ff) + POP_S - SLOT_W'(1) - SLOT_W'(req_data.word_index);
      commit       = SLOT_W'(fill_ff) + POP_S;
      free_slots   = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               res_in.buffer_handle  = '0;
               res_in.buffer_valid   = 1'b0;
               res_in.status         = ST_OK;
               res_in.refill_request = 1'b0;
               state_in              = FSM_HOLD;
               case (action_type'(req_data.action))
                  ACT_USE: begin
                     if (hip_ff) begin
                        res_in.status = ST_BUSY;
                     end else if (fill_ff == '0) begin
                        res_in.status = ST_UNDERFLOW;
                     end else begin
                        fill_in             = fill_ff - CNT_W'(1);
                        mem_re              = 1'b1;
                        res_in.buffer_valid = 1'b1;
                        state_in            = FSM_POP;
                     end
                  end
                  ACT_WORD: begin
                     if ((halves_ff & hbit) == 2'b00) begin
                        if (req_data.word_index < POP_W && slot < DEPTH_S) begin
                           mem_we    = 1'b1;
                           mem_waddr = slot[ADDR_W-1:0];
                        end else begin
                           res_in.status = ST_OVERFLOW;
                        end
                        if (req_data.last_word) begin
                           if (commit > DEPTH_S) begin
                              fill_in       = DEPTH_C;
                              res_in.status = ST_OVERFLOW;
                           end else begin
                              fill_in = commit[CNT_W-1:0];
                           end
                           halves_in = halves_ff | hbit;
                           hip_in    = 1'b0;
                        end else begin
                           hip_in = 1'b1;
                        end
                     end
                  end
                  ACT_FAIL: begin
                     if ((halves_ff & hbit) == 2'b00) begin
                        halves_in = halves_ff | hbit;
                        hip_in    = 1'b0;
                     end
                  end
                  ACT_SAFE: begin
                     safe_start = 1'b1;
                     state_in   = FSM_SAFE;
                  end
                  default: begin
                  end
               endcase

               // refill check on the updated state; safe requests change neither
               free_slots = DEPTH_C - fill_in;
               if (halves_in == HALVES_ALL && CMP_W'(free_slots) > CMP_W'(wm_ff)) begin
                  halves_in             = 2'b00;
                  res_in.refill_request = 1'b1;
               end
               res_in.available = 9'(fill_in);
               res_in.safe_seq  = safe_seq_ff;
            end
         end
         FSM_POP: begin
            res_in.buffer_handle = mem_rdata;
            state_in             = FSM_HOLD;
         end
         FSM_SAFE: begin
            if (safe_done) begin
               safe_seq_in     = safe_result;
               res_in.safe_seq = safe_result;
               state_in        = FSM_HOLD;
            end
         end
         FSM_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         fill_ff      <= '0;
         halves_ff    <= HALVES_ALL;
         hip_ff       <= 1'b0;
         safe_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         halves_ff    <= halves_in;
         hip_ff       <= hip_in;
         safe_seq_ff  <= safe_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm_ff         <= WM_RESET;
         dma_limit_ff  <= DMA_RESET;
         ring_limit_ff <= RING_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_WATERMARK:  wm_ff         <= csr_wdata[WM_W-1:0];
            CSR_DMA_LIMIT:  dma_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_RING_LIMIT: ring_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/bclr_store.sv -----
`timescale 1ns / 1ps
module bclr_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bclr_safe.sv -----
`timescale 1ns / 1ps
module bclr_safe #(
   parameter int CNT_W      = 9,
   parameter int BATCH_SIZE = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bclr_pkg::safe_args_type args,
   input  logic [CNT_W-1:0]       fill,
   output logic                   done,
   output logic [31:0]            result
);
   import bclr_pkg::*;

   // fill / BATCH_SIZE by reciprocal multiply, then one correction step
   localparam int DIV_SHIFT = CNT_W + 7;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = CNT_W + RECIP_W;
   localparam int REM_W     = CNT_W + 7;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / BATCH_SIZE);
   localparam logic [6:0]         BATCH_C = 7'(BATCH_SIZE);

   logic              v1_ff, v2_ff, v3_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]  x_ff;
   logic [SEQ_W-1:0]  dma_bat_ff, ring_bat_ff, issued1_ff, issued2_ff;
   logic [SEQ_W-1:0]  dma_bat2_ff, ring_bat2_ff;
   logic [CNT_W-1:0]  batches_ff;
   logic [SEQ_W-1:0]  result_ff;

   logic [CNT_W-1:0]  q0;
   logic [REM_W-1:0]  rem;
   logic [CNT_W-1:0]  batches_in;
   logic [SEQ_W-1:0]  min_a, min_b;

   always_comb begin
      q0  = prod_ff[DIV_SHIFT +: CNT_W];
      rem = REM_W'(x_ff) - REM_W'(q0) * REM_W'(BATCH_C);
      batches_in = (rem >= REM_W'(BATCH_C)) ? q0 + CNT_W'(1) : q0;
      min_a = (dma_bat2_ff < SEQ_W'(batches_ff)) ? dma_bat2_ff : SEQ_W'(batches_ff);
      min_b = (ring_bat2_ff < min_a) ? ring_bat2_ff : min_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= PROD_W'(fill) * PROD_W'(RECIP);
      x_ff        <= fill;
      dma_bat_ff  <= SEQ_W'(args.dma_limit) - args.issued_seq + args.completed_seq;
      ring_bat_ff <= SEQ_W'(args.ring_limit) - args.issued_seq + args.served_seq;
      issued1_ff  <= args.issued_seq;

      batches_ff   <= batches_in;
      dma_bat2_ff  <= dma_bat_ff;
      ring_bat2_ff <= ring_bat_ff;
      issued2_ff   <= issued1_ff;

      result_ff <= issued2_ff + min_b;
   end

   assign done   = v3_ff;
   assign result = result_ff;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import bclr_pkg::*;

   localparam int STORE_DEPTH   = 256;
   localparam int POP_SIZE      = 16;
   localparam int BATCH_SIZE    = 4;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;

   class handle_cache_scoreboard;
      logic [31:0] handles [STORE_DEPTH];
      bit          written [STORE_DEPTH];
      int unsigned fill;
      logic [1:0]  done_mask;
      bit          in_progress;
      logic [31:0] safe_reg;
      logic [8:0]  watermark;
      logic [15:0] dma_limit;
      logic [15:0] ring_limit;
      rsp_type     expected_q [$];
      int          errors;

      function new();
         fill = 0;
         done_mask = HALVES_ALL;
         in_progress = 0;
         safe_reg = '0;
         watermark = WM_RESET;
         dma_limit = DMA_RESET;
         ring_limit = RING_RESET;
         errors = 0;
         foreach (written[i]) written[i] = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_WATERMARK:  watermark = value[8:0];
            CSR_DMA_LIMIT:  dma_limit = value;
            CSR_RING_LIMIT: ring_limit = value;
            default: ;
         endcase
      endfunction

      // a pop must never land on a slot that was never loaded
      function bit use_defined();
         return in_progress || fill == 0 || written[fill - 1];
      endfunction

      // slot a refill word lands in, -1 when the word is dropped
      function int word_slot(req_type r);
         int slot;
         slot = int'(fill) + POP_SIZE - 1 - int'(r.word_index);
         if (r.word_index >= POP_SIZE || slot >= STORE_DEPTH) return -1;
         return slot;
      endfunction

      // true when a closing word would only commit loaded slots
      function bit commit_defined(req_type r);
         logic [1:0] hbit;
         int         slot;
         int         end_slot;
         hbit = r.half ? HALF_HI : HALF_LO;
         if (!r.last_word || (done_mask & hbit) != 0) return 1;
         slot = word_slot(r);
         end_slot = int'(fill) + POP_SIZE;
         if (end_slot > STORE_DEPTH) end_slot = STORE_DEPTH;
         for (int s = int'(fill); s < end_slot; s++) begin
            if (!written[s] && s != slot) return 0;
         end
         return 1;
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         logic [1:0]  hbit;
         int          slot;
         int unsigned next_fill;
         logic [31:0] batches;
         logic [31:0] dma_room;
         logic [31:0] ring_room;
         e = '0;
         hbit = r.half ? HALF_HI : HALF_LO;
         case (action_type'(r.action))
            ACT_USE: begin
               if (in_progress) begin
                  e.status = ST_BUSY;
               end else if (fill == 0) begin
                  e.status = ST_UNDERFLOW;
               end else begin
                  fill--;
                  e.buffer_handle = handles[fill];
                  e.buffer_valid = 1'b1;
               end
            end
            ACT_WORD: begin
               if ((done_mask & hbit) == 0) begin
                  slot = word_slot(r);
                  if (slot >= 0) begin
                     handles[slot] = r.buffer_word;
                     written[slot] = 1;
                  end else begin
                     e.status = ST_OVERFLOW;
                  end
                  if (r.last_word) begin
                     next_fill = fill + POP_SIZE;
                     if (next_fill > STORE_DEPTH) begin
                        next_fill = STORE_DEPTH;
                        e.status = ST_OVERFLOW;
                     end
                     fill = next_fill;
                     done_mask |= hbit;
                     in_progress = 0;
                  end else begin
                     in_progress = 1;
                  end
               end
            end
            ACT_FAIL: begin
               if ((done_mask & hbit) == 0) begin
                  done_mask |= hbit;
                  in_progress = 0;
               end
            end
            default: begin
               batches = fill / BATCH_SIZE;
               dma_room = 32'(dma_limit) - r.issued_seq + r.completed_seq;
               ring_room = 32'(ring_limit) - r.issued_seq + r.served_seq;
               if (dma_room < batches) batches = dma_room;
               if (ring_room < batches) batches = ring_room;
               safe_reg = r.issued_seq + batches;
            end
         endcase
         if (done_mask == HALVES_ALL && STORE_DEPTH - fill > watermark) begin
            done_mask = '0;
            e.refill_request = 1'b1;
         end
         e.available = 9'(fill);
         e.safe_seq = safe_reg;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("buffer_handle", want.buffer_handle, got.buffer_handle);
         compare_field("buffer_valid", want.buffer_valid, got.buffer_valid);
         compare_field("status", want.status, got.status);
         compare_field("refill_request", want.refill_request, got.refill_request);
         compare_field("available", want.available, got.available);
         compare_field("safe_seq", want.safe_seq, got.safe_seq);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   handle_cache_scoreboard cache_model = new();

   int hold_cycles = 0;
   bit no_idle = 0;
   int idle_count = 0;
   bit stream_on = 0;
   bit stream_half = 0;
   int stream_idx = 0;

   buffer_cache_lifo_refill #(
      .STORE_DEPTH(STORE_DEPTH),
      .POP_SIZE(POP_SIZE),
      .BATCH_SIZE(BATCH_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] seq_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 20);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_req(action_type act, bit half, int idx,
                                        logic [31:0] word, bit last);
      req_type r;
      r.action = act;
      r.half = half;
      r.word_index = 5'(idx);
      r.buffer_word = word;
      r.last_word = last;
      r.issued_seq = $urandom;
      r.completed_seq = $urandom;
      r.served_seq = $urandom;
      return r;
   endfunction

   task automatic next_request(input int word_pct, input int use_pct, output req_type r);
      int pick;
      r = make_req(ACT_SAFE, 0, 0, $urandom, 0);
      r.issued_seq = seq_value();
      // keep the sequence gaps small most of the time so every operand can win the min
      r.completed_seq = ($urandom_range(0, 3) == 0) ? $urandom
                        : r.issued_seq - $urandom_range(0, 40);
      r.served_seq = ($urandom_range(0, 3) == 0) ? $urandom
                     : r.issued_seq - $urandom_range(0, 40);
      if (stream_on && cache_model.done_mask[stream_half]) stream_on = 0;
      if (cache_model.done_mask != HALVES_ALL && $urandom_range(0, 99) < word_pct) begin
         if (!stream_on) begin
            stream_on = 1;
            stream_idx = 0;
            // with one half outstanding, bit 0 of the done mask names the other half
            if (cache_model.done_mask == '0) stream_half = 1'($urandom_range(0, 1));
            else stream_half = cache_model.done_mask[0];
         end
         r.action = ACT_WORD;
         r.half = stream_half;
         r.word_index = 5'(stream_idx);
         r.last_word = (stream_idx >= POP_SIZE - 1);
         case ($urandom_range(0, 39))
            0: r.word_index = 5'($urandom_range(POP_SIZE, 31));
            1: r.last_word = 1'b1;
            2: stream_idx++;
            default: ;
         endcase
         stream_idx++;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < use_pct) begin
            r.action = ACT_USE;
         end else if (pick >= 90) begin
            r.action = 2'($urandom_range(0, 3));
            r.half = 1'($urandom_range(0, 1));
            r.word_index = 5'($urandom_range(0, 31));
            r.last_word = 1'($urandom_range(0, 1));
         end
      end
      if (r.action == ACT_USE && !cache_model.use_defined()) r.action = ACT_SAFE;
      if (r.action == ACT_WORD && !cache_model.commit_defined(r)) r.action = ACT_FAIL;
   endtask

   task automatic send_request(req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      cache_model.note_request(r);
   endtask

   task automatic write_csrs(logic [15:0] wm, logic [15:0] dma, logic [15:0] ring);
      csr_write_en <= 1'b1;
      csr_index <= CSR_WATERMARK;
      csr_wdata <= wm;
      @(posedge clock);
      cache_model.write_reg(CSR_WATERMARK, wm);
      csr_index <= CSR_DMA_LIMIT;
      csr_wdata <= dma;
      @(posedge clock);
      cache_model.write_reg(CSR_DMA_LIMIT, dma);
      csr_index <= CSR_RING_LIMIT;
      csr_wdata <= ring;
      @(posedge clock);
      cache_model.write_reg(CSR_RING_LIMIT, ring);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(int wm, int dma, int ring, int count,
                            int word_pct, int use_pct, bit with_hold);
      req_type r;
      while (cache_model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csrs(16'(wm), 16'(dma), 16'(ring));
      for (int k = 0; k < count; k++) begin
         if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         // long receiver hold so the block backs up into the request side
         if (with_hold && k == 20) hold_cycles = HOLD_CYCLES;
         next_request(word_pct, use_pct, r);
         send_request(r);
      end
      req_valid <= 1'b0;
   endtask

   initial begin : response_sink
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = no_idle ? 0 : $urandom_range(0, 5);
         if (hold_cycles > 0) begin
            wait_cycles = hold_cycles;
            hold_cycles = 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         cache_model.check_response(rsp_data);
      end
   end

   initial begin : stimulus
      req_type r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty cache, then safe sequence at the wrap extremes
      send_request(make_req(ACT_USE, 0, 0, '0, 0));
      r = make_req(ACT_SAFE, 0, 0, '0, 0);
      r.issued_seq = '1;
      r.completed_seq = '0;
      r.served_seq = '1;
      send_request(r);
      r.issued_seq = '0;
      r.completed_seq = '1;
      r.served_seq = '0;
      send_request(r);
      // out of range word index opens a half, a pop is refused meanwhile
      send_request(make_req(ACT_WORD, 0, 31, '1, 0));
      send_request(make_req(ACT_USE, 1, 0, '0, 1));
      send_request(make_req(ACT_FAIL, 0, 0, '0, 0));
      // half already closed: word and failure are both ignored
      send_request(make_req(ACT_WORD, 0, 0, $urandom, 1));
      send_request(make_req(ACT_FAIL, 0, 0, '0, 0));
      for (int i = 0; i < POP_SIZE; i++)
         send_request(make_req(ACT_WORD, 1, i, (i == 0) ? '0 : (i == 1) ? '1 : $urandom,
                               i == POP_SIZE - 1));
      send_request(make_req(ACT_USE, 0, 0, '0, 0));
      send_request(make_req(ACT_SAFE, 0, 0, '0, 0));
      req_valid <= 1'b0;

      run_phase(0, 16'hFFFF, 16'hFFFF, 350, 85, 5, 0);
      run_phase(256, 0, 0, 350, 40, 85, 1);
      run_phase($urandom_range(0, 256), $urandom_range(0, 65535), $urandom_range(0, 65535),
                125, 55, 30, 0);
      run_phase(128, 40, 20, 125, 55, 35, 0);
      run_phase($urandom_range(0, 256), $urandom_range(0, 64), $urandom_range(0, 64),
                125, 55, 30, 0);
      run_phase(WM_RESET, DMA_RESET, RING_RESET, 125, 55, 30, 0);

      while (cache_model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (cache_model.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
